>>> src/pfrc_pkg.sv
// Shared types, constants and helper functions for the PPP frame receive checker.
// Used by the parsing core, the result queue and the top level.
`default_nettype none

package pfrc_pkg;

  localparam logic [15:0] FCS_INIT = 16'hffff;
  localparam logic [15:0] FCS_GOOD = 16'hf0b8;
  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [7:0]  HDR_ADDR = 8'hff;
  localparam logic [7:0]  HDR_CTRL = 8'h03;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REG_SYNC_MODE          = 2'd0;
  localparam logic [1:0] REG_ADDR_CTRL_COMPRESS = 2'd1;
  localparam logic [1:0] REG_PROTO_COMPRESS     = 2'd2;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_CTRL   = 3'd1,
    PH_LOOK   = 3'd2,
    PH_PROTO  = 3'd3,
    PH_PROTO2 = 3'd4,
    PH_BODY   = 3'd5,
    PH_DROP   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADFCS  = 3'd1,
    ST_SHORT   = 3'd2,
    ST_BADADDR = 3'd3,
    ST_BADCTRL = 3'd4
  } status_t;

  typedef struct packed {
    logic sync_mode;
    logic addr_ctrl_compress;
    logic proto_compress;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_status;
    logic [2:0]  frame_status;
    logic [15:0] protocol;
  } res_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
    res_t a;
    res_t b;
  } push_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] acc;
    logic        emit;
  } pfeed_t;

  function automatic logic [15:0] fcs_step(logic [15:0] fcs, logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ FCS_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic pfeed_t proto_feed(phase_t ph, logic [15:0] acc, logic pc,
                                        logic [7:0] b);
    pfeed_t r;
    r.phase = ph;
    r.acc   = acc;
    r.emit  = 1'b0;
    case (ph)
      PH_PROTO: begin
        if (pc) begin
          r.acc = {acc[7:0], b};
          if (b[0]) begin
            r.phase = PH_BODY;
          end
        end else begin
          r.acc   = {b, 8'h00};
          r.phase = PH_PROTO2;
        end
      end
      PH_PROTO2: begin
        r.acc   = acc | {8'h00, b};
        r.phase = PH_BODY;
      end
      PH_BODY: begin
        r.emit = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/pfrc_ifs.sv
// Handshake interfaces for the byte input channel and the result channel.
// Both carry valid, ready and the word's payload; no package dependency.
`default_nettype none

interface pfrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pfrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_status;
  logic [2:0]  frame_status;
  logic [15:0] protocol;
  modport source (output valid, output out_byte, output is_status, output frame_status,
                  output protocol, input ready);
  modport sink   (input valid, input out_byte, input is_status, input frame_status,
                  input protocol, output ready);
endinterface

`default_nettype wire

>>> src/pfrc_core.sv
// Frame state, FCS register, FCS holdback and header/protocol parsing.
// Depends on pfrc_pkg and pfrc_in_if; hands up to two results per word to the queue.
`default_nettype none

module pfrc_core
  import pfrc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  space_ok,
  pfrc_in_if.sink    in_ch,
  output push_t      push
);

  logic [15:0] fcs_r, fcs_nxt;
  logic [7:0]  hb0_r, hb0_nxt, hb1_r, hb1_nxt;
  logic [1:0]  hb_cnt_r, hb_cnt_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  look_r, look_nxt;
  logic [15:0] proto_r, proto_nxt;
  logic [1:0]  body_r, body_nxt;
  status_t     herr_r, herr_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic        feed_en;
  logic [7:0]  feed_b;
  logic        emit;
  status_t     st;
  pfeed_t      pf_a, pf_b, pf_c;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;

  always_comb begin
    feed_en = 1'b0;
    feed_b  = hb0_r;
    if (cfg.sync_mode) begin
      feed_en = 1'b1;
      feed_b  = b;
    end else if (!last) begin
      feed_en = (hb_cnt_r == 2'd2);
    end else begin
      feed_en = (hb_cnt_r == 2'd2);
    end
  end

  assign pf_a = proto_feed(PH_PROTO, proto_r, cfg.proto_compress, look_r);
  assign pf_b = proto_feed(pf_a.phase, pf_a.acc, cfg.proto_compress, feed_b);
  assign pf_c = proto_feed(phase_r, proto_r, cfg.proto_compress, feed_b);

  always_comb begin
    fcs_nxt    = fcs_r;
    hb0_nxt    = hb0_r;
    hb1_nxt    = hb1_r;
    hb_cnt_nxt = hb_cnt_r;
    phase_nxt  = phase_r;
    look_nxt   = look_r;
    proto_nxt  = proto_r;
    body_nxt   = body_r;
    herr_nxt   = herr_r;
    emit       = 1'b0;
    st         = ST_OK;
    push       = '0;

    if (accept) begin
      fcs_nxt = fcs_step(fcs_r, b);

      if (!cfg.sync_mode && !last) begin
        if (hb_cnt_r == 2'd0) begin
          hb0_nxt    = b;
          hb_cnt_nxt = 2'd1;
        end else if (hb_cnt_r == 2'd1) begin
          hb1_nxt    = b;
          hb_cnt_nxt = 2'd2;
        end else begin
          hb0_nxt = hb1_r;
          hb1_nxt = b;
        end
      end

      if (feed_en) begin
        if (body_r != 2'd2) begin
          body_nxt = body_r + 2'd1;
        end
        case (phase_r)
          PH_FIRST: begin
            if (cfg.addr_ctrl_compress) begin
              look_nxt  = feed_b;
              phase_nxt = PH_LOOK;
            end else if (feed_b != HDR_ADDR) begin
              herr_nxt  = ST_BADADDR;
              phase_nxt = PH_DROP;
            end else begin
              phase_nxt = PH_CTRL;
            end
          end
          PH_CTRL: begin
            if (feed_b != HDR_CTRL) begin
              herr_nxt  = ST_BADCTRL;
              phase_nxt = PH_DROP;
            end else begin
              phase_nxt = PH_PROTO;
            end
          end
          PH_LOOK: begin
            phase_nxt = PH_PROTO;
            if (!(look_r == HDR_ADDR && feed_b == HDR_CTRL)) begin
              phase_nxt = pf_b.phase;
              proto_nxt = pf_b.acc;
              emit      = pf_b.emit;
            end
          end
          PH_PROTO, PH_PROTO2, PH_BODY: begin
            phase_nxt = pf_c.phase;
            proto_nxt = pf_c.acc;
            emit      = pf_c.emit;
          end
          default: begin
          end
        endcase
      end

      if (!cfg.sync_mode && fcs_nxt != FCS_GOOD) begin
        st = ST_BADFCS;
      end else if (body_nxt != 2'd2) begin
        st = ST_SHORT;
      end else if (herr_nxt != ST_OK) begin
        st = herr_nxt;
      end else if (phase_nxt != PH_BODY) begin
        st = ST_SHORT;
      end else begin
        st = ST_OK;
      end

      if (emit) begin
        push.en_a       = 1'b1;
        push.a.out_byte = feed_b;
        if (last) begin
          push.en_b           = 1'b1;
          push.b.is_status    = 1'b1;
          push.b.frame_status = st;
          push.b.protocol     = (phase_nxt == PH_BODY) ? proto_nxt : 16'h0000;
        end
      end else if (last) begin
        push.en_a           = 1'b1;
        push.a.is_status    = 1'b1;
        push.a.frame_status = st;
        push.a.protocol     = (phase_nxt == PH_BODY) ? proto_nxt : 16'h0000;
      end

      if (last) begin
        fcs_nxt    = FCS_INIT;
        hb0_nxt    = 8'h00;
        hb1_nxt    = 8'h00;
        hb_cnt_nxt = 2'd0;
        phase_nxt  = PH_FIRST;
        look_nxt   = 8'h00;
        proto_nxt  = 16'h0000;
        body_nxt   = 2'd0;
        herr_nxt   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_r    <= FCS_INIT;
      hb0_r    <= 8'h00;
      hb1_r    <= 8'h00;
      hb_cnt_r <= 2'd0;
      phase_r  <= PH_FIRST;
      look_r   <= 8'h00;
      proto_r  <= 16'h0000;
      body_r   <= 2'd0;
      herr_r   <= ST_OK;
    end else begin
      fcs_r    <= fcs_nxt;
      hb0_r    <= hb0_nxt;
      hb1_r    <= hb1_nxt;
      hb_cnt_r <= hb_cnt_nxt;
      phase_r  <= phase_nxt;
      look_r   <= look_nxt;
      proto_r  <= proto_nxt;
      body_r   <= body_nxt;
      herr_r   <= herr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/pfrc_outq.sv
// Small result queue that takes up to two results a cycle and releases one.
// Depends on pfrc_pkg and pfrc_out_if; its fill level sets the input ready.
`default_nettype none

module pfrc_outq
  import pfrc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space_ok,
  pfrc_out_if.source out_ch
);

  res_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QCNT_W-1:0] n_push;
  res_t              head;

  assign head                = q_r[rd_ptr_r];
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.is_status    = head.is_status;
  assign out_ch.frame_status = head.frame_status;
  assign out_ch.protocol     = head.protocol;

  assign space_ok = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop      = out_ch.valid && out_ch.ready;
  assign n_push   = QCNT_W'(push.en_a) + QCNT_W'(push.en_b);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.en_a) begin
      q_r[wr_ptr_r] <= push.a;
    end
    if (push.en_b) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/ppp_frame_receive_check.sv
// PPP frame receive checker: FCS-16 check, header strip and protocol parse.
// A word's results are written into the registered result queue, which drives the result channel.
// Throughput: one byte word per cycle; a frame's last word may add a status word, so the
// four-entry result queue, which sets ready, paces the input at the result rate.
// Reset: synchronous and active low; clears the configuration, frame state and queue.
// Depends on pfrc_pkg, pfrc_ifs, pfrc_core and pfrc_outq.
`default_nettype none

module ppp_frame_receive_check
  import pfrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  pfrc_in_if.sink         in_ch,
  pfrc_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic       cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  push_t push;
  logic  space_ok;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_MODE:          cfg_nxt.sync_mode          = cfg_data;
        REG_ADDR_CTRL_COMPRESS: cfg_nxt.addr_ctrl_compress = cfg_data;
        REG_PROTO_COMPRESS:     cfg_nxt.proto_compress     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfrc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .space_ok (space_ok),
    .in_ch    (in_ch),
    .push     (push)
  );

  pfrc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
